[src/cam_pkg.sv]
package cam_pkg;

  localparam int unsigned DefSlots           = 4;
  localparam int unsigned DefChannelsPerSlot = 128;
  localparam int unsigned DefSampleBits      = 16;

  localparam int unsigned MaxSlots = 16;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned LimW     = 9;

  localparam logic [15:0] DecayStart  = 16'd128;
  localparam logic [15:0] PeakFloor   = 16'd2;
  localparam logic [15:0] QuietWrap   = 16'h8000;
  localparam logic [15:0] CountMax    = 16'hFFFF;

  typedef enum logic [1:0] {
    CmdSample,
    CmdFlush,
    CmdDrop
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                           kind;
    logic                                found;
    logic [SlotW-1:0]                    slot;
    logic [6:0]                          channel;
    logic [15:0]                         left;
    logic [15:0]                         right;
    logic [MaxSlots-1:0][LimW-1:0]       lim;
  } cmd_t;

endpackage

[src/cam_fifo.sv]
module cam_fifo
  import cam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t din_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t dout_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= din_i;
  end

endmodule

[src/cam_front.sv]
module cam_front
  import cam_pkg::*;
#(
  parameter int unsigned SLOTS             = DefSlots,
  parameter int unsigned CHANNELS_PER_SLOT = DefChannelsPerSlot
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [4:0]  chip_id_i,
  input  logic [7:0]  channel_count_i,
  input  logic [6:0]  channel_i,
  input  logic [15:0] left_i,
  input  logic [15:0] right_i,
  input  logic        full_i,
  input  logic        clearing_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic signed [2:0] forced_q;
  logic [MaxSlots-1:0]       valid_q;
  logic [MaxSlots-1:0][4:0]  chip_q;
  logic [MaxSlots-1:0][7:0]  chans_q;

  logic             sel_found, sel_new, prefix;
  logic [SlotW-1:0] sel;
  logic [LimW-1:0]  lim_v;

  assign in_ready_o = !full_i && !clearing_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    sel_found = 1'b0;
    sel_new   = 1'b0;
    sel       = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_q[s] || chip_q[s] == chip_id_i) begin
        sel_found = 1'b1;
        sel_new   = !valid_q[s];
        sel       = SlotW'(s);
      end
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.channel = channel_i;
    cmd_o.left    = left_i;
    cmd_o.right   = right_i;
    prefix        = 1'b1;
    for (int s = 0; s < MaxSlots; s++) begin
      lim_v = '0;
      if (s < SLOTS) begin
        prefix = prefix && valid_q[s];
        if (prefix) begin
          lim_v = (LimW'(chans_q[s]) > LimW'(CHANNELS_PER_SLOT)) ?
                  LimW'(CHANNELS_PER_SLOT) : LimW'(chans_q[s]);
        end
      end
      cmd_o.lim[s] = lim_v;
    end
    if (operation_i) begin
      cmd_o.kind = CmdFlush;
    end else begin
      if (forced_q < 0) begin
        cmd_o.found = sel_found;
        cmd_o.slot  = sel;
      end else begin
        cmd_o.found = 32'(forced_q[1:0]) < SLOTS;
        cmd_o.slot  = SlotW'(forced_q[1:0]);
      end
      if (!cmd_o.found) begin
        cmd_o.kind = CmdDrop;
        cmd_o.slot = '0;
      end else if (32'(channel_i) >= CHANNELS_PER_SLOT) begin
        cmd_o.kind = CmdDrop;
      end else begin
        cmd_o.kind = CmdSample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forced_q <= -3'sd1;
      valid_q  <= '0;
      chip_q   <= '0;
      chans_q  <= '0;
    end else begin
      if (cfg_we_i) forced_q <= cfg_data_i;
      if (push_o && !operation_i && forced_q < 0 && sel_found && sel_new) begin
        valid_q[sel] <= 1'b1;
        chip_q[sel]  <= chip_id_i;
        chans_q[sel] <= channel_count_i;
      end
    end
  end

endmodule

[src/cam_div.sv]
module cam_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [15:0] rem_q, div_q;
  logic [31:0] quot_q;
  logic [16:0] sh;
  logic        ge;

  assign sh     = {rem_q, quot_q[31]};
  assign ge     = sh >= {1'b0, div_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 5'd31;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      div_q  <= divisor_i;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= ge ? 16'(sh - {1'b0, div_q}) : sh[15:0];
      quot_q <= {quot_q[30:0], ge};
    end
  end

endmodule

[src/cam_back.sv]
module cam_back
  import cam_pkg::*;
#(
  parameter int unsigned SLOTS             = DefSlots,
  parameter int unsigned CHANNELS_PER_SLOT = DefChannelsPerSlot,
  parameter int unsigned SAMPLE_BITS       = DefSampleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        clearing_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        slot_found_o,
  output logic [1:0]  slot_o,
  output logic [15:0] shown_left_o,
  output logic [15:0] shown_right_o,
  output logic [15:0] peak_o
);

  localparam int unsigned Nch = SLOTS * CHANNELS_PER_SLOT;
  localparam int unsigned AW  = (Nch > 1) ? $clog2(Nch) : 1;
  localparam int unsigned LW  = $clog2(CHANNELS_PER_SLOT + 1);
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned XW  = (SB > 16) ? SB : 16;

  typedef struct packed {
    logic [SB-1:0] prev_l;
    logic [SB-1:0] prev_r;
    logic [31:0]   acc_l;
    logic [31:0]   acc_r;
    logic [15:0]   cnt;
    logic [15:0]   quiet;
    logic [15:0]   peak;
    logic [15:0]   shown_l;
    logic [15:0]   shown_r;
  } word_t;

  typedef enum logic [3:0] {
    SClear, SIdle, SRd, SCalc, SFlNext, SFlRd, SFlChk, SFlDl, SFlDr, SOut
  } state_e;

  state_e           state_q;
  cmd_t             cmd_q;
  logic [AW-1:0]    addr_q;
  logic [SlotW-1:0] fl_slot_q;
  logic [LW-1:0]    fl_ch_q;
  logic [15:0]      ql_q;
  word_t            mem_q [Nch];
  word_t            rd_q;
  word_t            wdata, upd;
  logic             we;
  logic             out_valid_q, found_q;
  logic [1:0]       slot_q;
  logic [15:0]      sl_q, sr_q, pk_q;
  logic             div_start, div_done;
  logic [31:0]      div_dividend, quot;
  logic [15:0]      qsat;
  logic [15:0]      pk0, pk1, q1;
  logic [AW-1:0]    smp_addr, fl_addr;
  logic [LimW-1:0]  cur_lim;

  function automatic logic [SB-1:0] smp_bits(input logic [15:0] raw);
    logic [XW-1:0] ext;
    ext = XW'(raw);
    return ext[SB-1:0];
  endfunction

  function automatic logic [SB:0] abs_diff(input logic [SB-1:0] a, input logic [SB-1:0] b);
    logic signed [SB:0] d;
    d = $signed({a[SB-1], a}) - $signed({b[SB-1], b});
    return d[SB] ? (SB+1)'(-d) : d;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [SB:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  cam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (rd_q.cnt),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign qsat         = (|quot[31:16]) ? 16'hFFFF : quot[15:0];
  assign div_dividend = (state_q == SFlChk) ? rd_q.acc_l : rd_q.acc_r;
  assign div_start    = (state_q == SFlChk && rd_q.cnt != 16'd0) ||
                        (state_q == SFlDl && div_done);
  assign smp_addr     = AW'(cmd_i.slot) * AW'(CHANNELS_PER_SLOT) + AW'(cmd_i.channel);
  assign fl_addr      = AW'(fl_slot_q) * AW'(CHANNELS_PER_SLOT) + AW'(fl_ch_q);
  assign cur_lim      = cmd_q.lim[fl_slot_q];
  assign pop_o        = state_q == SIdle && !empty_i;
  assign clearing_o   = state_q == SClear;

  always_comb begin
    pk0 = rd_q.peak;
    if (rd_q.quiet > DecayStart && rd_q.quiet[4:0] == 5'd0 && rd_q.peak > PeakFloor) begin
      pk0 = rd_q.peak - 16'd1;
    end
    if (pk0 > PeakFloor && rd_q.shown_l < pk0 && rd_q.shown_r < pk0) begin
      q1 = (rd_q.quiet == 16'hFFFF) ? QuietWrap : rd_q.quiet + 16'd1;
    end else begin
      q1 = '0;
    end
    pk1 = pk0;
    if (rd_q.shown_l > pk1) pk1 = rd_q.shown_l;
    if (rd_q.shown_r > pk1) pk1 = rd_q.shown_r;
    upd        = rd_q;
    upd.prev_l = smp_bits(cmd_q.left);
    upd.prev_r = smp_bits(cmd_q.right);
    upd.acc_l  = sat_add(rd_q.acc_l, abs_diff(smp_bits(cmd_q.left), rd_q.prev_l));
    upd.acc_r  = sat_add(rd_q.acc_r, abs_diff(smp_bits(cmd_q.right), rd_q.prev_r));
    upd.cnt    = (rd_q.cnt == CountMax) ? CountMax : rd_q.cnt + 16'd1;
    upd.quiet  = q1;
    upd.peak   = pk1;
  end

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    unique case (state_q)
      SClear: we = 1'b1;
      SCalc: begin
        we    = 1'b1;
        wdata = upd;
      end
      SFlDr: begin
        we            = div_done;
        wdata         = rd_q;
        wdata.acc_l   = '0;
        wdata.acc_r   = '0;
        wdata.cnt     = '0;
        wdata.shown_l = ql_q;
        wdata.shown_r = qsat;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr_q] <= wdata;
    rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      cmd_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      fl_slot_q   <= '0;
      fl_ch_q     <= '0;
      ql_q        <= '0;
      found_q     <= 1'b0;
      slot_q      <= '0;
      sl_q        <= '0;
      sr_q        <= '0;
      pk_q        <= '0;
    end else begin
      unique case (state_q)
        SClear: begin
          if (addr_q == AW'(Nch - 1)) state_q <= SIdle;
          else addr_q <= addr_q + AW'(1);
        end
        SIdle: begin
          if (!empty_i) begin
            cmd_q     <= cmd_i;
            addr_q    <= smp_addr;
            fl_slot_q <= '0;
            fl_ch_q   <= '0;
            found_q   <= cmd_i.found;
            slot_q    <= 2'(cmd_i.slot);
            sl_q      <= '0;
            sr_q      <= '0;
            pk_q      <= '0;
            unique case (cmd_i.kind)
              CmdSample: state_q <= SRd;
              CmdFlush:  state_q <= SFlNext;
              default: begin
                out_valid_q <= 1'b1;
                state_q     <= SOut;
              end
            endcase
          end
        end
        SRd: state_q <= SCalc;
        SCalc: begin
          sl_q        <= rd_q.shown_l;
          sr_q        <= rd_q.shown_r;
          pk_q        <= pk1;
          out_valid_q <= 1'b1;
          state_q     <= SOut;
        end
        SFlNext: begin
          if (LimW'(fl_ch_q) < cur_lim) begin
            addr_q  <= fl_addr;
            state_q <= SFlRd;
          end else if (fl_slot_q == SlotW'(SLOTS - 1)) begin
            out_valid_q <= 1'b1;
            state_q     <= SOut;
          end else begin
            fl_slot_q <= fl_slot_q + SlotW'(1);
            fl_ch_q   <= '0;
          end
        end
        SFlRd: state_q <= SFlChk;
        SFlChk: begin
          if (rd_q.cnt == 16'd0) begin
            fl_ch_q <= fl_ch_q + LW'(1);
            state_q <= SFlNext;
          end else begin
            state_q <= SFlDl;
          end
        end
        SFlDl: begin
          if (div_done) begin
            ql_q    <= qsat;
            state_q <= SFlDr;
          end
        end
        SFlDr: begin
          if (div_done) begin
            fl_ch_q <= fl_ch_q + LW'(1);
            state_q <= SFlNext;
          end
        end
        SOut: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign slot_found_o  = found_q;
  assign slot_o        = slot_q;
  assign shown_left_o  = sl_q;
  assign shown_right_o = sr_q;
  assign peak_o        = pk_q;

  a_calc_only_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SCalc) |-> (cmd_q.kind == CmdSample))
    else $error("sample update on a non-sample command");

  a_div_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFlDl && div_done) |=> (state_q == SFlDr && !div_done))
    else $error("right division did not start after left");

  a_out_in_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == SOut))
    else $error("result valid outside output state");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !out_valid_q)
    else $error("command popped while result pending");

endmodule

[src/channel_activity_meter.sv]
// channel activity meter
// input channel: in_valid_i/in_ready_o with operation, chip id, channel count,
// channel and a stereo sample; one result item per input item on
// out_valid_o/out_ready_i
// configuration: cfg_we_i writes the forced slot from cfg_data_i at once
// a front stage resolves the chip slot in the accept cycle and queues a
// command in a two-entry queue; a back stage updates the per-channel memory
// sample item: SIdle, SRd and SCalc do a read-modify-write of the single-port
// channel memory; the next command is popped only once the result is taken
// flush item: walks each channel of every used slot; SFlNext, SFlRd, SFlChk
// for each, and SFlDl then SFlDr if it has samples, on the shared bit-serial
// divider doing left then right; its all-zero result comes at the end
// reset: slot table empties and a clearing pass zeroes every word of the
// channel memory, with in_ready_o low until it ends
// receiver stall: the result holds in the output register, the front keeps
// taking items until the queue is full, then in_ready_o drops
module channel_activity_meter
  import cam_pkg::*;
#(
  parameter int unsigned SLOTS             = DefSlots,
  parameter int unsigned CHANNELS_PER_SLOT = DefChannelsPerSlot,
  parameter int unsigned SAMPLE_BITS       = DefSampleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [4:0]  chip_id_i,
  input  logic [7:0]  channel_count_i,
  input  logic [6:0]  channel_i,
  input  logic [15:0] left_i,
  input  logic [15:0] right_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        slot_found_o,
  output logic [1:0]  slot_o,
  output logic [15:0] shown_left_o,
  output logic [15:0] shown_right_o,
  output logic [15:0] peak_o
);

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty, clearing;

  cam_front #(
    .SLOTS             (SLOTS),
    .CHANNELS_PER_SLOT (CHANNELS_PER_SLOT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .chip_id_i       (chip_id_i),
    .channel_count_i (channel_count_i),
    .channel_i       (channel_i),
    .left_i          (left_i),
    .right_i         (right_i),
    .full_i          (full),
    .clearing_i      (clearing),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  cam_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (pop_cmd),
    .empty_o (empty)
  );

  cam_back #(
    .SLOTS             (SLOTS),
    .CHANNELS_PER_SLOT (CHANNELS_PER_SLOT),
    .SAMPLE_BITS       (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_found_o  (slot_found_o),
    .slot_o        (slot_o),
    .shown_left_o  (shown_left_o),
    .shown_right_o (shown_right_o),
    .peak_o        (peak_o)
  );

endmodule
